[src/bgspf_pkg.sv]
// Shared types and constants for the bit-granular store with pattern find.
package bgspf_pkg;

	localparam int POS_W = 24;
	localparam int ADDR_W = 19;
	localparam int DATA_W = 8;
	localparam int PAT_DIGITS = 16;
	localparam int DEF_STORE_BYTES = 65536;
	localparam int DEF_MAX_DIGITS = 16;
	localparam logic [3:0] FW_RESET = 4'd4;
	localparam logic [4:0] PCNT_RESET = 5'd1;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_FIND  = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FAIL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_FIELD_WIDTH   = 3'd0,
		CFG_BUFFER_BYTES  = 3'd1,
		CFG_PATTERN_VALUE = 3'd2,
		CFG_PATTERN_COUNT = 3'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		K_DONE,
		K_LOAD,
		K_READ,
		K_WRITE,
		K_FIND
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RD,
		B_BIT
	} back_state_t;

	typedef struct packed {
		logic [3:0]       fw;
		logic [4:0]       pcnt;
		logic [63:0]      pat;
		logic [POS_W-1:0] lim;
		logic [8:0]       len;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		status_t           status;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] field;
		logic [ADDR_W-1:0] found;
	} res_t;

endpackage

[src/bit_granular_store_with_pattern_find_core.sv]
// Top level of the bit-granular store with pattern find.
//
// Requests enter through push/full with command, address and data; each request
// gives exactly one result, delivered in order through empty/pop on status,
// field and found_at. Configuration goes in through cfg_valid/cfg_ready
// (always ready) with cfg_index and cfg_data; the user must write it only
// while no request is pending, which the block does not enforce. The front
// classifies each request and settles all range and width errors at once; a
// two-entry queue carries it to the back, which owns the byte store. Errors
// and loads give their result as the back takes them; read, write and find
// alternate a read of the single store read port and a step on one bit of it.
// One request is worked on at a time. Results wait in a two-entry queue;
// while it is full the back holds, and the front keeps taking requests until
// its queue fills. Reset clears the queues and the engine and restores
// register defaults; the store keeps no reset value and needs no clearing pass.
module bit_granular_store_with_pattern_find_core #(
	parameter int STORE_BYTES = bgspf_pkg::DEF_STORE_BYTES,
	parameter int MAX_DIGITS = bgspf_pkg::DEF_MAX_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    command,
	input  logic [bgspf_pkg::ADDR_W-1:0]  address,
	input  logic [bgspf_pkg::DATA_W-1:0]  data,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic [bgspf_pkg::DATA_W-1:0]  field,
	output logic [bgspf_pkg::ADDR_W-1:0]  found_at,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [63:0]                   cfg_data
);

	bgspf_pkg::cmd_t cmd_in;
	bgspf_pkg::cmd_t cmd_out;
	bgspf_pkg::cfg_t cfg;
	bgspf_pkg::res_t res_in;
	bgspf_pkg::res_t res_out;
	logic            cmd_push;
	logic            cmd_full;
	logic            cmd_pop;
	logic            cmd_empty;
	logic            res_push;
	logic            res_full;

	// Request classification and configuration.
	bgspf_front #(
		.STORE_BYTES(STORE_BYTES),
		.MAX_DIGITS(MAX_DIGITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.command(command),
		.address(address),
		.data(data),
		.q_full(cmd_full),
		.q_push(cmd_push),
		.cmd(cmd_in),
		.cfg(cfg)
	);

	// Queue between front and back.
	bgspf_fifo #(
		.WIDTH($bits(bgspf_pkg::cmd_t)),
		.DEPTH(2)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_push),
		.wr_data(cmd_in),
		.full(cmd_full),
		.rd_en(cmd_pop),
		.rd_data(cmd_out),
		.empty(cmd_empty)
	);

	// Store and execution engine.
	bgspf_back #(
		.STORE_BYTES(STORE_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	// Result queue toward the receiver.
	bgspf_fifo #(
		.WIDTH($bits(bgspf_pkg::res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_push),
		.wr_data(res_in),
		.full(res_full),
		.rd_en(pop),
		.rd_data(res_out),
		.empty(empty)
	);

	assign status = res_out.status;
	assign field = res_out.field;
	assign found_at = res_out.found;

	// The back never produces a result into a full result queue.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result produced while result queue full");

	// The back only takes requests that are present.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> !cmd_empty)
		else $error("request taken from empty queue");

	// A delivered status is always a defined code.
	assert property (@(posedge clk) disable iff (!arst_n) !empty |-> status != 2'd3)
		else $error("undefined status code on result port");

endmodule

[src/bgspf_fifo.sv]
// Small register queue used between the front, the back and the result port.
module bgspf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = entry_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[src/bgspf_front.sv]
// Front end: configuration registers and classification of each request.
module bgspf_front #(
	parameter int STORE_BYTES = bgspf_pkg::DEF_STORE_BYTES,
	parameter int MAX_DIGITS = bgspf_pkg::DEF_MAX_DIGITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [63:0]                     cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      command,
	input  logic [bgspf_pkg::ADDR_W-1:0]    address,
	input  logic [bgspf_pkg::DATA_W-1:0]    data,
	input  logic                            q_full,
	output logic                            q_push,
	output bgspf_pkg::cmd_t                 cmd,
	output bgspf_pkg::cfg_t                 cfg
);

	logic [3:0]                   fw_q;
	logic [16:0]                  bb_q;
	logic [63:0]                  pat_q;
	logic [4:0]                   pcnt_q;
	logic [3:0]                   fw_v;
	logic [4:0]                   pcnt_v;
	logic [bgspf_pkg::POS_W-1:0]  bb_ext;
	logic [bgspf_pkg::POS_W-1:0]  store_pos;
	logic [bgspf_pkg::POS_W-1:0]  lim;
	logic [bgspf_pkg::POS_W-1:0]  addr_pos;
	logic [8:0]                   len;
	logic                         bad_digit;

	assign cfg_ready = 1'b1;
	assign full = q_full;
	assign q_push = push && !q_full;

	// Clamp or filter incoming configuration values.
	always_comb begin
		fw_v = cfg_data[3:0];
		pcnt_v = cfg_data[4:0];
		if (pcnt_v == 5'd0) begin
			pcnt_v = 5'd1;
		end else if (pcnt_v > 5'(MAX_DIGITS)) begin
			pcnt_v = 5'(MAX_DIGITS);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bgspf_pkg::FW_RESET;
			bb_q <= '0;
			pat_q <= '0;
			pcnt_q <= bgspf_pkg::PCNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bgspf_pkg::CFG_FIELD_WIDTH: begin
					if (fw_v >= 4'd1 && fw_v <= 4'd8) begin
						fw_q <= fw_v;
					end
				end
				bgspf_pkg::CFG_BUFFER_BYTES: begin
					bb_q <= cfg_data[16:0];
				end
				bgspf_pkg::CFG_PATTERN_VALUE: begin
					pat_q <= cfg_data;
				end
				bgspf_pkg::CFG_PATTERN_COUNT: begin
					pcnt_q <= pcnt_v;
				end
				default: begin
				end
			endcase
		end
	end

	// Valid bit count and coded pattern length.
	always_comb begin
		bb_ext = bgspf_pkg::POS_W'(bb_q);
		store_pos = bgspf_pkg::POS_W'(STORE_BYTES);
		lim = ((bb_ext > store_pos) ? store_pos : bb_ext) << 3;
		len = 9'(pcnt_q) * 9'(fw_q);
		addr_pos = bgspf_pkg::POS_W'(address);
	end

	// A pattern digit in use that does not fit the field width.
	always_comb begin
		bad_digit = 1'b0;
		for (int k = 0; k < bgspf_pkg::PAT_DIGITS; k++) begin
			if (5'(k) < pcnt_q && (pat_q[63 - 4 * k -: 4] >> fw_q) != 4'd0) begin
				bad_digit = 1'b1;
			end
		end
	end

	assign cfg.fw = fw_q;
	assign cfg.pcnt = pcnt_q;
	assign cfg.pat = pat_q;
	assign cfg.lim = lim;
	assign cfg.len = len;

	// Classify the request: errors are settled here, the rest goes to the back end.
	always_comb begin
		cmd.addr = address;
		cmd.data = data;
		cmd.status = bgspf_pkg::ST_OK;
		cmd.kind = bgspf_pkg::K_DONE;
		case (command)
			bgspf_pkg::CMD_LOAD: begin
				if (addr_pos >= store_pos) begin
					cmd.status = bgspf_pkg::ST_RANGE;
				end else begin
					cmd.kind = bgspf_pkg::K_LOAD;
				end
			end
			bgspf_pkg::CMD_READ: begin
				if (addr_pos >= lim) begin
					cmd.status = bgspf_pkg::ST_RANGE;
				end else begin
					cmd.kind = bgspf_pkg::K_READ;
				end
			end
			bgspf_pkg::CMD_WRITE: begin
				if (addr_pos >= lim) begin
					cmd.status = bgspf_pkg::ST_RANGE;
				end else if ((data >> fw_q) != 8'd0) begin
					cmd.status = bgspf_pkg::ST_FAIL;
				end else begin
					cmd.kind = bgspf_pkg::K_WRITE;
				end
			end
			default: begin
				if (bad_digit) begin
					cmd.status = bgspf_pkg::ST_FAIL;
				end else if (addr_pos >= lim) begin
					cmd.status = bgspf_pkg::ST_RANGE;
				end else if (addr_pos + bgspf_pkg::POS_W'(len) > lim) begin
					cmd.status = bgspf_pkg::ST_FAIL;
				end else begin
					cmd.kind = bgspf_pkg::K_FIND;
				end
			end
		endcase
	end

endmodule

[src/bgspf_back.sv]
// Back end: byte store and the bit-serial engine for read, write and find.
module bgspf_back #(
	parameter int STORE_BYTES = bgspf_pkg::DEF_STORE_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bgspf_pkg::cfg_t cfg,
	input  bgspf_pkg::cmd_t cmd,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  logic            res_full,
	output logic            res_push,
	output bgspf_pkg::res_t res
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int PW = bgspf_pkg::POS_W;

	logic [7:0]                 mem [STORE_BYTES];
	logic [7:0]                 rdata_q;
	bgspf_pkg::back_state_t     state_q;
	bgspf_pkg::back_state_t     state_d;
	bgspf_pkg::kind_t           kind_q;
	logic [PW-1:0]              pos_q;
	logic [PW-1:0]              i_q;
	logic [7:0]                 data_q;
	logic [7:0]                 fld_q;
	logic [2:0]                 b_q;
	logic [3:0]                 k_q;
	logic                       mem_we;
	logic                       mem_re;
	logic [AW-1:0]              mem_wa;
	logic [7:0]                 mem_wd;
	logic [AW-1:0]              byte_idx;
	logic [2:0]                 bit_idx;
	logic                       bit_v;
	logic                       inr;
	logic                       last_b;
	logic                       last_k;
	logic [3:0]                 sh;
	logic [7:0]                 dig8;
	logic                       exp_bit;
	logic [PW-1:0]              nxt_i;
	logic                       miss_end;
	logic                       start;

	// Per-bit helpers for the current position.
	always_comb begin
		byte_idx = pos_q[AW+2:3];
		bit_idx = 3'd7 - pos_q[2:0];
		bit_v = rdata_q[bit_idx];
		inr = pos_q < cfg.lim;
		last_b = ({1'b0, b_q} == cfg.fw - 4'd1);
		last_k = (5'(k_q) == cfg.pcnt - 5'd1);
		sh = cfg.fw - 4'd1 - {1'b0, b_q};
		dig8 = {4'd0, cfg.pat[{~k_q, 2'b11} -: 4]};
		exp_bit = dig8[sh[2:0]];
		nxt_i = i_q + PW'(cfg.fw);
		miss_end = (nxt_i + PW'(cfg.len)) > cfg.lim;
	end

	// Next state, queue handshakes, memory controls and results.
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		res.status = bgspf_pkg::ST_OK;
		res.field = '0;
		res.found = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = AW'(cmd.addr);
		mem_wd = cmd.data;
		start = 1'b0;
		case (state_q)
			bgspf_pkg::B_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						bgspf_pkg::K_DONE: begin
							res_push = 1'b1;
							res.status = cmd.status;
						end
						bgspf_pkg::K_LOAD: begin
							mem_we = 1'b1;
							res_push = 1'b1;
						end
						default: begin
							start = 1'b1;
							state_d = bgspf_pkg::B_RD;
						end
					endcase
				end
			end
			bgspf_pkg::B_RD: begin
				mem_re = 1'b1;
				state_d = bgspf_pkg::B_BIT;
			end
			bgspf_pkg::B_BIT: begin
				state_d = bgspf_pkg::B_RD;
				case (kind_q)
					bgspf_pkg::K_READ: begin
						if (last_b) begin
							res_push = 1'b1;
							res.field = {fld_q[6:0], inr & bit_v};
							state_d = bgspf_pkg::B_IDLE;
						end
					end
					bgspf_pkg::K_WRITE: begin
						mem_we = inr;
						mem_wa = byte_idx;
						mem_wd = rdata_q;
						mem_wd[bit_idx] = data_q[sh[2:0]];
						if (last_b) begin
							res_push = 1'b1;
							state_d = bgspf_pkg::B_IDLE;
						end
					end
					default: begin
						if (bit_v != exp_bit) begin
							if (miss_end) begin
								res_push = 1'b1;
								res.status = bgspf_pkg::ST_FAIL;
								state_d = bgspf_pkg::B_IDLE;
							end
						end else if (last_b && last_k) begin
							res_push = 1'b1;
							res.found = bgspf_pkg::ADDR_W'(i_q);
							state_d = bgspf_pkg::B_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = bgspf_pkg::B_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgspf_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Position, digit and bit counters of the engine.
	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= cmd.kind;
			pos_q <= PW'(cmd.addr);
			i_q <= PW'(cmd.addr);
			data_q <= cmd.data;
			fld_q <= '0;
			b_q <= '0;
			k_q <= '0;
		end else if (state_q == bgspf_pkg::B_BIT) begin
			if (kind_q == bgspf_pkg::K_FIND && bit_v != exp_bit) begin
				i_q <= nxt_i;
				pos_q <= nxt_i;
				b_q <= '0;
				k_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				fld_q <= {fld_q[6:0], inr & bit_v};
				if (last_b) begin
					b_q <= '0;
					k_q <= k_q + 1'b1;
				end else begin
					b_q <= b_q + 1'b1;
				end
			end
		end
	end

	// Byte store with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[byte_idx];
		end
	end

endmodule
